/* hw/rtl/cfr_pkg.sv */
// Shared constants and types for the framed byte receiver.
`default_nettype none

package cfr_pkg;

  // Encoded frame buffer size; the store keeps at most BUF_SIZE-1 bytes
  localparam int BUF_SIZE   = 64;
  localparam int ADDR_W     = $clog2(BUF_SIZE);
  localparam int FILL_MAX   = BUF_SIZE - 1;
  localparam int LEN_W      = 6;
  localparam int BYTE_W     = 8;
  localparam int CODE_W     = 9;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // Byte codes
  localparam logic [BYTE_W-1:0] MARKER_BYTE  = 8'h00;
  localparam logic [BYTE_W-1:0] CODE_NO_ZERO = 8'hFF;
  localparam logic [BYTE_W-1:0] CODE_SINGLE  = 8'h01;

  // Classified receive transaction
  typedef struct packed {
    logic                is_marker;
    logic [BYTE_W-1:0]   data;
  } cfr_entry_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC_RD,
    ST_DEC_USE,
    ST_DEC_ZERO,
    ST_EM_RD,
    ST_EM_WAIT,
    ST_EM_EMPTY
  } cfr_state_t;

endpackage

`default_nettype wire

/* hw/rtl/cfr_front.sv */
// Front end: accepts received bytes and tags frame markers.
`default_nettype none

module cfr_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [cfr_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                           push_valid,
  input  wire logic                      push_ready,
  output cfr_pkg::cfr_entry_t            push_entry
);

  logic                hold_valid_r, hold_valid_nxt;
  cfr_pkg::cfr_entry_t hold_r, hold_nxt;
  logic                accept, push;

  // Single holding register; refills in the cycle it drains
  assign push     = hold_valid_r && push_ready;
  assign in_ready = !hold_valid_r || push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    if (accept) begin
      hold_valid_nxt      = 1'b1;
      hold_nxt.is_marker  = (in_rx_byte == cfr_pkg::MARKER_BYTE);
      hold_nxt.data       = in_rx_byte;
    end else if (push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  assign push_valid = hold_valid_r;
  assign push_entry = hold_r;

endmodule

`default_nettype wire

/* hw/rtl/cfr_queue.sv */
// Short queue of classified bytes between front and back.
`default_nettype none

module cfr_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire cfr_pkg::cfr_entry_t push_entry,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output cfr_pkg::cfr_entry_t      pop_entry
);

  cfr_pkg::cfr_entry_t             slot_r [cfr_pkg::FIFO_DEPTH];
  logic [cfr_pkg::FIFO_PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [cfr_pkg::FIFO_PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [cfr_pkg::FIFO_PTR_W:0]    count_r, count_nxt;
  logic                            do_push, do_pop;

  assign push_ready = (count_r != (cfr_pkg::FIFO_PTR_W+1)'(cfr_pkg::FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and occupancy update
  always_comb begin
    wptr_nxt  = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = do_pop  ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cfr_back.sv */
// Back end: frame store, byte-unstuffing walk, checksum and result output.
`default_nettype none

module cfr_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       pop_valid,
  output logic                            pop_ready,
  input  wire cfr_pkg::cfr_entry_t        pop_entry,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [cfr_pkg::BYTE_W-1:0]      out_data_byte,
  output logic                            out_data_valid,
  output logic                            out_last,
  output logic [cfr_pkg::LEN_W-1:0]       out_frame_length,
  output logic                            out_checksum_ok
);

  localparam int AW = cfr_pkg::ADDR_W;
  localparam int BW = cfr_pkg::BYTE_W;

  cfr_pkg::cfr_state_t state_r, state_nxt;

  logic [AW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] n_r, n_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [BW-1:0] remain_r, remain_nxt;
  logic          ff_r, ff_nxt;
  logic [BW-1:0] xor_r, xor_nxt;
  logic [BW-1:0] byte0_r, byte0_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [BW-1:0] out_data_r, out_data_nxt;
  logic          out_dv_r, out_dv_nxt;
  logic          out_last_r, out_last_nxt;
  logic [cfr_pkg::LEN_W-1:0] out_len_r, out_len_nxt;
  logic          out_ok_r, out_ok_nxt;

  // Memories
  logic [BW-1:0] enc_mem [cfr_pkg::BUF_SIZE];
  logic [BW-1:0] dec_mem [cfr_pkg::BUF_SIZE];
  logic [BW-1:0] enc_rdata_r, dec_rdata_r;
  logic          enc_we, dec_we;
  logic [BW-1:0] dec_wdata;

  // Walk helpers
  logic [cfr_pkg::CODE_W-1:0] run_end;
  logic          overrun, done, slot_free, out_load, is_last;
  logic [AW-1:0] rd_inc;

  assign rd_inc    = rd_r + 1'b1;
  assign run_end   = cfr_pkg::CODE_W'(rd_r) + cfr_pkg::CODE_W'(enc_rdata_r);
  assign overrun   = (run_end > cfr_pkg::CODE_W'(n_r)) || (enc_rdata_r == cfr_pkg::MARKER_BYTE);
  assign done      = (rd_inc == n_r);
  assign slot_free = !out_valid_r || out_ready;
  assign is_last   = (k_r == wr_r - 1'b1);
  assign pop_ready = (state_r == cfr_pkg::ST_IDLE);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    n_nxt        = n_r;
    rd_nxt       = rd_r;
    wr_nxt       = wr_r;
    k_nxt        = k_r;
    remain_nxt   = remain_r;
    ff_nxt       = ff_r;
    xor_nxt      = xor_r;
    byte0_nxt    = byte0_r;
    enc_we       = 1'b0;
    dec_we       = 1'b0;
    dec_wdata    = enc_rdata_r;
    out_load     = 1'b0;
    out_data_nxt = out_data_r;
    out_dv_nxt   = out_dv_r;
    out_last_nxt = out_last_r;
    out_len_nxt  = out_len_r;
    out_ok_nxt   = out_ok_r;

    case (state_r)
      cfr_pkg::ST_IDLE: begin
        if (pop_valid) begin
          if (!pop_entry.is_marker) begin
            if (fill_r < AW'(cfr_pkg::FILL_MAX)) begin
              enc_we   = 1'b1;
              fill_nxt = fill_r + 1'b1;
            end
          end else begin
            n_nxt      = fill_r;
            fill_nxt   = '0;
            rd_nxt     = '0;
            wr_nxt     = '0;
            remain_nxt = '0;
            ff_nxt     = 1'b0;
            xor_nxt    = '0;
            byte0_nxt  = '0;
            state_nxt  = (fill_r == '0) ? cfr_pkg::ST_EM_EMPTY : cfr_pkg::ST_DEC_RD;
          end
        end
      end

      cfr_pkg::ST_DEC_RD: begin
        state_nxt = cfr_pkg::ST_DEC_USE;
      end

      cfr_pkg::ST_DEC_USE: begin
        rd_nxt = rd_inc;
        if (remain_r == '0) begin
          // code byte opens a group
          if (overrun) begin
            state_nxt = cfr_pkg::ST_EM_EMPTY;
          end else begin
            remain_nxt = enc_rdata_r - 1'b1;
            ff_nxt     = (enc_rdata_r == cfr_pkg::CODE_NO_ZERO);
            if (done) begin
              k_nxt     = '0;
              state_nxt = (wr_r == '0) ? cfr_pkg::ST_EM_EMPTY : cfr_pkg::ST_EM_RD;
            end else if (enc_rdata_r == cfr_pkg::CODE_SINGLE) begin
              state_nxt = cfr_pkg::ST_DEC_ZERO;
            end else begin
              state_nxt = cfr_pkg::ST_DEC_RD;
            end
          end
        end else begin
          // data byte copied through
          dec_we     = 1'b1;
          dec_wdata  = enc_rdata_r;
          wr_nxt     = wr_r + 1'b1;
          remain_nxt = remain_r - 1'b1;
          if (wr_r == '0) begin
            byte0_nxt = enc_rdata_r;
          end else begin
            xor_nxt = xor_r ^ enc_rdata_r;
          end
          if (done) begin
            k_nxt     = '0;
            state_nxt = cfr_pkg::ST_EM_RD;
          end else if (remain_r == BW'(1) && !ff_r) begin
            state_nxt = cfr_pkg::ST_DEC_ZERO;
          end else begin
            state_nxt = cfr_pkg::ST_DEC_RD;
          end
        end
      end

      cfr_pkg::ST_DEC_ZERO: begin
        // implied zero at group end
        dec_we    = 1'b1;
        dec_wdata = '0;
        wr_nxt    = wr_r + 1'b1;
        if (wr_r == '0) begin
          byte0_nxt = '0;
        end
        state_nxt = cfr_pkg::ST_DEC_RD;
      end

      cfr_pkg::ST_EM_RD: begin
        state_nxt = cfr_pkg::ST_EM_WAIT;
      end

      cfr_pkg::ST_EM_WAIT: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_data_nxt = dec_rdata_r;
          out_dv_nxt   = 1'b1;
          out_last_nxt = is_last;
          out_len_nxt  = is_last ? cfr_pkg::LEN_W'(wr_r) : '0;
          out_ok_nxt   = is_last && (wr_r >= AW'(2)) && (xor_r == byte0_r);
          k_nxt        = k_r + 1'b1;
          state_nxt    = is_last ? cfr_pkg::ST_IDLE : cfr_pkg::ST_EM_RD;
        end
      end

      cfr_pkg::ST_EM_EMPTY: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_data_nxt = '0;
          out_dv_nxt   = 1'b0;
          out_last_nxt = 1'b1;
          out_len_nxt  = '0;
          out_ok_nxt   = 1'b0;
          state_nxt    = cfr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = cfr_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfr_pkg::ST_IDLE;
      fill_r      <= '0;
      rd_r        <= '0;
      wr_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Walk payload and output payload
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    remain_r   <= remain_nxt;
    ff_r       <= ff_nxt;
    xor_r      <= xor_nxt;
    byte0_r    <= byte0_nxt;
    out_data_r <= out_data_nxt;
    out_dv_r   <= out_dv_nxt;
    out_last_r <= out_last_nxt;
    out_len_r  <= out_len_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  // Encoded frame store
  always_ff @(posedge clk) begin
    if (enc_we) begin
      enc_mem[fill_r] <= pop_entry.data;
    end
    enc_rdata_r <= enc_mem[rd_r];
  end

  // Decoded frame store
  always_ff @(posedge clk) begin
    if (dec_we) begin
      dec_mem[wr_r] <= dec_wdata;
    end
    dec_rdata_r <= dec_mem[k_r];
  end

  assign out_valid        = out_valid_r;
  assign out_data_byte    = out_data_r;
  assign out_data_valid   = out_dv_r;
  assign out_last         = out_last_r;
  assign out_frame_length = out_len_r;
  assign out_checksum_ok  = out_ok_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= AW'(cfr_pkg::FILL_MAX))
    else $error("encoded store fill above limit");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != cfr_pkg::ST_IDLE |-> wr_r <= rd_r)
    else $error("decoded index passed encoded index");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cfr_pkg::ST_EM_RD || state_r == cfr_pkg::ST_EM_WAIT) |-> k_r < wr_r)
    else $error("emit index beyond decoded length");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |=> state_r == cfr_pkg::ST_IDLE)
    else $error("sequencer busy after final result");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != cfr_pkg::ST_IDLE) |-> !enc_we)
    else $error("store write while frame in progress");

endmodule

`default_nettype wire

/* hw/rtl/cobs_frame_receiver_xor_check.sv */
// Top level of the framed byte receiver with XOR checksum verdict.
//
// Input channel (in_valid/in_ready/in_rx_byte): one received byte per
// transaction. Non-zero bytes go into a 64-entry frame store, at most 63
// per frame, extra bytes dropped. A zero byte closes the frame.
// Output channel (out_valid/out_ready/out_*): one transaction per decoded
// byte, out_last on the final one, which also carries out_frame_length and
// out_checksum_ok. Empty or malformed frames give a single transaction with
// out_data_valid low and out_last high.
// A front register and a 4-entry queue take bytes while the back end works.
// Data bytes are written to the store while the back end is idle. After
// the closing zero the back end walks the frame store, reading and then
// using each encoded byte and writing each implied zero, then reads out
// and emits the decoded bytes in order; each store has one read port.
// A stall on out_ready holds the output register and halts the emission of
// decoded bytes; the queue then fills and in_ready drops.
// rst_n (synchronous, active low) empties the queue, zeroes the fill count
// and returns the back end to idle; no clearing pass is needed.
`default_nettype none

module cobs_frame_receiver_xor_check (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cfr_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cfr_pkg::BYTE_W-1:0]       out_data_byte,
  output logic                             out_data_valid,
  output logic                             out_last,
  output logic [cfr_pkg::LEN_W-1:0]        out_frame_length,
  output logic                             out_checksum_ok
);

  logic                push_valid, push_ready;
  cfr_pkg::cfr_entry_t push_entry;
  logic                pop_valid, pop_ready;
  cfr_pkg::cfr_entry_t pop_entry;

  cfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  cfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  cfr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_entry        (pop_entry),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_byte    (out_data_byte),
    .out_data_valid   (out_data_valid),
    .out_last         (out_last),
    .out_frame_length (out_frame_length),
    .out_checksum_ok  (out_checksum_ok)
  );

endmodule

`default_nettype wire

/* bench/frame_result_checker.sv */
// Checker for the framed byte receiver: predicts decoded frames and compares results.
module frame_result_checker
  import cfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [BYTE_W-1:0] out_data_byte,
  input  wire logic              out_data_valid,
  input  wire logic              out_last,
  input  wire logic [LEN_W-1:0]  out_frame_length,
  input  wire logic              out_checksum_ok,
  output int                     error_count,
  output int                     results_waiting
);

  localparam int MAX_LEN       = FILL_MAX - 1;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              data_valid;
    logic              last;
    logic [LEN_W-1:0]  frame_length;
    logic              checksum_ok;
  } frame_result_t;

  logic [BYTE_W-1:0] enc_frame [BUF_SIZE];
  logic [BYTE_W-1:0] dec_frame [BUF_SIZE];
  int                fill_level;
  frame_result_t     frame_results_q[$];

  // Unstuff the stored frame into dec_frame; 0 when a code runs past the end
  function automatic int unstuff_frame();
    int rd;
    int wr;
    int code;
    int k;
    rd = 0;
    wr = 0;
    while (rd < fill_level) begin
      code = int'(enc_frame[rd]);
      if (code == 0 || rd + code > fill_level)
        return 0;
      rd++;
      for (k = 1; k < code; k++) begin
        if (wr < BUF_SIZE)
          dec_frame[wr] = enc_frame[rd];
        wr++;
        rd++;
      end
      // implied zero, except for a full group or the final group
      if (code != CODE_NO_ZERO && rd != fill_level) begin
        if (wr < BUF_SIZE)
          dec_frame[wr] = MARKER_BYTE;
        wr++;
      end
    end
    return wr;
  endfunction

  // Marker seen: decode, work out the verdict and queue the frame's results
  task automatic close_frame();
    int                len;
    int                k;
    logic [BYTE_W-1:0] sum;
    logic              sum_ok;
    frame_result_t     r;
    len = unstuff_frame();
    fill_level = 0;
    if (len > MAX_LEN)
      len = MAX_LEN;
    sum_ok = 1'b0;
    if (len >= 2) begin
      sum = '0;
      for (k = 1; k < len; k++)
        sum ^= dec_frame[k];
      sum_ok = (sum == dec_frame[0]);
    end
    if (len == 0) begin
      r = '0;
      r.last = 1'b1;
      frame_results_q.push_back(r);
    end else begin
      for (k = 0; k < len; k++) begin
        r.data_byte    = dec_frame[k];
        r.data_valid   = 1'b1;
        r.last         = (k == len - 1);
        r.frame_length = r.last ? LEN_W'(len) : '0;
        r.checksum_ok  = r.last && sum_ok;
        frame_results_q.push_back(r);
      end
    end
  endtask

  // Compare one output transaction against the oldest expectation
  task automatic check_result();
    frame_result_t got;
    frame_result_t exp_r;
    got = {out_data_byte, out_data_valid, out_last, out_frame_length, out_checksum_ok};
    if (frame_results_q.size() == 0) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display("checker: unexpected result byte %h dv %b last %b len %0d ok %b",
                 got.data_byte, got.data_valid, got.last, got.frame_length,
                 got.checksum_ok);
    end else begin
      exp_r = frame_results_q.pop_front();
      if (got.data_byte !== exp_r.data_byte || got.data_valid !== exp_r.data_valid ||
          got.last !== exp_r.last || got.frame_length !== exp_r.frame_length ||
          got.checksum_ok !== exp_r.checksum_ok) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display({"checker: mismatch, expected byte %h dv %b last %b len %0d ok %b,",
                    " got byte %h dv %b last %b len %0d ok %b"},
                   exp_r.data_byte, exp_r.data_valid, exp_r.last, exp_r.frame_length,
                   exp_r.checksum_ok, got.data_byte, got.data_valid, got.last,
                   got.frame_length, got.checksum_ok);
      end
    end
  endtask

  // Watch both channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      fill_level = 0;
      error_count = 0;
      frame_results_q.delete();
    end else begin
      if (out_valid && out_ready)
        check_result();
      if (in_valid && in_ready) begin
        if (in_rx_byte == MARKER_BYTE) begin
          close_frame();
        end else if (fill_level + 1 < BUF_SIZE) begin
          enc_frame[fill_level] = in_rx_byte;
          fill_level++;
        end
      end
    end
    results_waiting = frame_results_q.size();
  end

endmodule

/* bench/testbench.sv */
// Top of the framed byte receiver testbench: stimulus, flow control and verdict.
module testbench;
  import cfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_PAYLOAD    = FILL_MAX - 1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_data_byte;
  logic              out_data_valid;
  logic              out_last;
  logic [LEN_W-1:0]  out_frame_length;
  logic              out_checksum_ok;

  int   error_count;
  int   results_waiting;
  int   send_idle_pct = 0;
  int   rx_stall_pct = 0;
  logic rx_hold = 1'b0;
  int   items_sent = 0;
  int   quiet_cycles = 0;

  logic [BYTE_W-1:0] payload_q[$];
  logic [BYTE_W-1:0] wire_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cobs_frame_receiver_xor_check DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_byte    (out_data_byte),
    .out_data_valid   (out_data_valid),
    .out_last         (out_last),
    .out_frame_length (out_frame_length),
    .out_checksum_ok  (out_checksum_ok)
  );

  frame_result_checker result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_byte    (out_data_byte),
    .out_data_valid   (out_data_valid),
    .out_last         (out_last),
    .out_frame_length (out_frame_length),
    .out_checksum_ok  (out_checksum_ok),
    .error_count      (error_count),
    .results_waiting  (results_waiting)
  );

  // Receiver: random stalls, fully closed during a hold-off
  always @(posedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // Watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input transaction, after a random gap
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_wire();
    foreach (wire_q[i])
      send_byte(wire_q[i]);
  endtask

  // Random payload, optionally with a matching checksum byte, stuffed and terminated
  task automatic make_frame(input int len, input bit fix_sum);
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] code;
    int                code_at;
    payload_q.delete();
    repeat (len) begin
      b = BYTE_W'($urandom_range(255));
      if ($urandom_range(99) < 20)
        b = MARKER_BYTE;
      payload_q.push_back(b);
    end
    if (fix_sum && len >= 2) begin
      b = '0;
      for (int i = 1; i < len; i++)
        b ^= payload_q[i];
      payload_q[0] = b;
    end
    // payloads stay below 254 bytes, so no full group is needed
    wire_q.delete();
    wire_q.push_back(CODE_SINGLE);
    code_at = 0;
    code = CODE_SINGLE;
    foreach (payload_q[i]) begin
      if (payload_q[i] == MARKER_BYTE) begin
        wire_q[code_at] = code;
        code_at = wire_q.size();
        wire_q.push_back(CODE_SINGLE);
        code = CODE_SINGLE;
      end else begin
        wire_q.push_back(payload_q[i]);
        code++;
      end
    end
    wire_q[code_at] = code;
    wire_q.push_back(MARKER_BYTE);
  endtask

  // Mostly well-formed frames; some corrupted ones and raw noise, some overflowing
  task automatic random_frame();
    int kind;
    int len;
    int n;
    kind = $urandom_range(99);
    if ($urandom_range(99) < 85)
      len = $urandom_range(16);
    else
      len = $urandom_range(MAX_PAYLOAD, 17);
    if (kind < 70) begin
      make_frame(len, 1'($urandom_range(1)));
    end else if (kind < 85) begin
      make_frame(len, 1'b0);
      wire_q[$urandom_range(wire_q.size() - 2)] = BYTE_W'($urandom_range(255, 1));
    end else begin
      n = ($urandom_range(99) < 30) ? $urandom_range(75, 50) : $urandom_range(20);
      wire_q.delete();
      repeat (n) wire_q.push_back(BYTE_W'($urandom_range(255, 1)));
      wire_q.push_back(MARKER_BYTE);
    end
    send_wire();
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int target);
    int stop_at;
    send_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    stop_at = items_sent + target;
    while (items_sent < stop_at)
      random_frame();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty frame
    wire_q = '{MARKER_BYTE};
    send_wire();
    // single byte payload, too short for a checksum
    wire_q = '{8'h02, 8'hFF, MARKER_BYTE};
    send_wire();
    // two equal bytes: checksum holds
    wire_q = '{8'h03, 8'hA5, 8'hA5, MARKER_BYTE};
    send_wire();
    // three bytes with a failing checksum
    wire_q = '{8'h04, 8'h01, 8'h80, 8'h7F, MARKER_BYTE};
    send_wire();
    // code running past the end of the frame
    wire_q = '{8'h05, 8'h11, 8'h22, MARKER_BYTE};
    send_wire();
    // full-group code, which cannot fit in the store
    wire_q = '{CODE_NO_ZERO, CODE_SINGLE, MARKER_BYTE};
    send_wire();
    // payload of two zero bytes, all implied
    wire_q = '{CODE_SINGLE, CODE_SINGLE, CODE_SINGLE, MARKER_BYTE};
    send_wire();

    // Back-pressure: receiver closed while long and overflowing frames go in
    fork
      begin
        @(negedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end
    join_none
    make_frame(MAX_PAYLOAD, 1'b1);
    send_wire();
    wire_q.delete();
    repeat (70) wire_q.push_back(BYTE_W'($urandom_range(255, 1)));
    wire_q.push_back(MARKER_BYTE);
    send_wire();

    // Random traffic under each flow-control mix
    run_phase(0, 0, 25);
    run_phase(82, 0, 25);
    run_phase(0, 82, 25);
    run_phase(21, 21, 25);
    in_valid <= 1'b0;

    // Drain remaining results, then let the block settle
    do @(negedge clk); while (results_waiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
